/* rtl/scpd_pkg.sv */
// shared types and constants for the servo command to pwm duty block
// depends on nothing; used by every module in rtl
`timescale 1ns / 1ps

package scpd_pkg;

  // duty resolution and output width
  localparam int DUTY_BITS = 13;
  localparam int DUTY_W    = DUTY_BITS + 1;
  localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(1) << DUTY_BITS;

  // register reset values
  localparam logic [8:0]  MIN_ANGLE_RST  = 9'd0;
  localparam logic [8:0]  MAX_ANGLE_RST  = 9'd180;
  localparam logic [15:0] MIN_PULSE_RST  = 16'd500;
  localparam logic [15:0] MAX_PULSE_RST  = 16'd2500;
  localparam logic [15:0] PERIOD_RST     = 16'd20000;

  // register indexes
  typedef enum logic [2:0] {
    REG_MIN_ANGLE = 3'd0,
    REG_MAX_ANGLE = 3'd1,
    REG_MIN_PULSE = 3'd2,
    REG_MAX_PULSE = 3'd3,
    REG_PERIOD    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] command_value;
  } in_word_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [15:0]       pulse_us;
    logic              error;
  } out_word_t;

  // handoff from the pulse mapper to the duty divider
  typedef struct packed {
    logic        valid;
    logic [15:0] pulse;
    logic        err;
  } pulse_word_t;

endpackage

/* rtl/servo_command_to_pwm_duty.sv */
// top level: configuration registers, pipeline enable and the two datapath units
// depends on scpd_pkg, scpd_map, scpd_duty
`timescale 1ns / 1ps

// Converts a servo command (angle or pulse width in microseconds) into a
// clamped pulse width and a duty of pulse * 2^13 / period, saturated at
// 2^13. One word is accepted every cycle while no result is stalled at the
// output; each result passes 19 stages in the angle mapper, whose long
// division yields one quotient bit per stage, and 15 in the duty divider,
// one bit per stage plus entry and exit registers. The whole pipeline
// advances together and holds while a result is stalled at the output.
// Registers may be written only while no word is in flight.
module servo_command_to_pwm_duty (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  scpd_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output scpd_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  logic [8:0]  min_angle_r;
  logic [8:0]  max_angle_r;
  logic [15:0] min_pulse_r;
  logic [15:0] max_pulse_r;
  logic [15:0] period_r;
  logic        en;
  scpd_pkg::pulse_word_t pw;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_angle_r <= scpd_pkg::MIN_ANGLE_RST;
      max_angle_r <= scpd_pkg::MAX_ANGLE_RST;
      min_pulse_r <= scpd_pkg::MIN_PULSE_RST;
      max_pulse_r <= scpd_pkg::MAX_PULSE_RST;
      period_r    <= scpd_pkg::PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        scpd_pkg::REG_MIN_ANGLE: min_angle_r <= cfg_data[8:0];
        scpd_pkg::REG_MAX_ANGLE: max_angle_r <= cfg_data[8:0];
        scpd_pkg::REG_MIN_PULSE: min_pulse_r <= cfg_data;
        scpd_pkg::REG_MAX_PULSE: max_pulse_r <= cfg_data;
        scpd_pkg::REG_PERIOD:    period_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // global pipeline advance
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  scpd_map u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_take   (in_valid),
    .in_word   (in_word),
    .min_angle (min_angle_r),
    .max_angle (max_angle_r),
    .min_pulse (min_pulse_r),
    .max_pulse (max_pulse_r),
    .pw        (pw)
  );

  scpd_duty u_duty (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .pw        (pw),
    .period    (period_r),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.error |-> out_word.duty == '0)
    else $error("error result with nonzero duty");

  a_duty_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.duty <= scpd_pkg::DUTY_FULL)
    else $error("duty above full scale");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result changed");

endmodule

/* rtl/scpd_map.sv */
// angle or pulse command to clamped pulse width, with pipelined long division
// depends on scpd_pkg
`timescale 1ns / 1ps

module scpd_map (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_take,
  input  scpd_pkg::in_word_t   in_word,
  input  logic [8:0]           min_angle,
  input  logic [8:0]           max_angle,
  input  logic [15:0]          min_pulse,
  input  logic [15:0]          max_pulse,
  output scpd_pkg::pulse_word_t pw
);

  localparam int QBITS = 16;

  typedef struct packed {
    logic        v;
    logic        mode;
    logic        err;
    logic        neg;
    logic [15:0] mag;
    logic [8:0]  off;
    logic [8:0]  rng;
    logic [15:0] pc;
  } a_t;

  typedef struct packed {
    logic        v;
    logic        mode;
    logic        err;
    logic        neg;
    logic [15:0] pc;
    logic [8:0]  rng;
    logic [24:0] prod;
  } b_t;

  typedef struct packed {
    logic        v;
    logic        mode;
    logic        err;
    logic        neg;
    logic [15:0] pc;
    logic [8:0]  rng;
    logic [8:0]  rem;
    logic [15:0] lo;
    logic [15:0] q;
  } d_t;

  a_t a_r, a_nxt;
  b_t b_r, b_nxt;
  d_t d_r [QBITS];
  d_t d_nxt [QBITS];
  scpd_pkg::pulse_word_t o_r, o_nxt;

  logic [15:0] ang;
  logic [15:0] pl;
  logic [16:0] span;

  // clamp, offsets and span sign
  always_comb begin
    ang = in_word.command_value;
    if (ang < {7'd0, min_angle}) ang = {7'd0, min_angle};
    if (ang > {7'd0, max_angle}) ang = {7'd0, max_angle};
    pl = in_word.command_value;
    if (pl < min_pulse) pl = min_pulse;
    if (pl > max_pulse) pl = max_pulse;
    span = {1'b0, max_pulse} - {1'b0, min_pulse};
    a_nxt.v    = in_take;
    a_nxt.mode = in_word.mode;
    a_nxt.err  = !in_word.mode && (max_angle <= min_angle);
    a_nxt.neg  = span[16];
    a_nxt.mag  = span[16] ? (min_pulse - max_pulse) : span[15:0];
    a_nxt.off  = ang[8:0] - min_angle;
    a_nxt.rng  = max_angle - min_angle;
    a_nxt.pc   = pl;
  end

  // span times offset
  always_comb begin
    b_nxt.v    = a_r.v;
    b_nxt.mode = a_r.mode;
    b_nxt.err  = a_r.err;
    b_nxt.neg  = a_r.neg;
    b_nxt.pc   = a_r.pc;
    b_nxt.rng  = a_r.rng;
    b_nxt.prod = 25'(a_r.mag) * 25'(a_r.off);
  end

  // one quotient bit per stage
  always_comb begin
    d_t   cur;
    logic [9:0] t;
    logic ge;
    for (int i = 0; i < QBITS; i++) begin
      if (i == 0) begin
        cur.v    = b_r.v;
        cur.mode = b_r.mode;
        cur.err  = b_r.err;
        cur.neg  = b_r.neg;
        cur.pc   = b_r.pc;
        cur.rng  = b_r.rng;
        cur.rem  = b_r.prod[24:16];
        cur.lo   = b_r.prod[15:0];
        cur.q    = '0;
      end else begin
        cur = d_r[i-1];
      end
      t  = {cur.rem, cur.lo[15]};
      ge = (t >= {1'b0, cur.rng});
      d_nxt[i]     = cur;
      d_nxt[i].rem = ge ? 9'(t - {1'b0, cur.rng}) : t[8:0];
      d_nxt[i].lo  = {cur.lo[14:0], 1'b0};
      d_nxt[i].q   = {cur.q[14:0], ge};
    end
  end

  // signed offset onto the pulse range, then select by mode; an angle error gives min_pulse
  always_comb begin
    o_nxt.valid = d_r[QBITS-1].v;
    o_nxt.err   = d_r[QBITS-1].err;
    if (d_r[QBITS-1].mode) begin
      o_nxt.pulse = d_r[QBITS-1].pc;
    end else if (d_r[QBITS-1].err) begin
      o_nxt.pulse = min_pulse;
    end else if (d_r[QBITS-1].neg) begin
      o_nxt.pulse = min_pulse - d_r[QBITS-1].q;
    end else begin
      o_nxt.pulse = min_pulse + d_r[QBITS-1].q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.v <= 1'b0;
      b_r.v <= 1'b0;
      o_r.valid <= 1'b0;
      for (int i = 0; i < QBITS; i++) d_r[i].v <= 1'b0;
    end else if (en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      o_r <= o_nxt;
      for (int i = 0; i < QBITS; i++) d_r[i] <= d_nxt[i];
    end
  end

  assign pw = o_r;

endmodule

/* rtl/scpd_duty.sv */
// pulse width to saturated duty, one quotient bit per pipeline stage
// depends on scpd_pkg
`timescale 1ns / 1ps

module scpd_duty (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  scpd_pkg::pulse_word_t pw,
  input  logic [15:0]           period,
  output logic                  out_valid,
  output scpd_pkg::out_word_t   out_word
);

  localparam int NB = scpd_pkg::DUTY_BITS;

  typedef struct packed {
    logic          v;
    logic          err;
    logic          sat;
    logic [15:0]   pulse;
    logic [15:0]   rem;
    logic [NB-1:0] q;
  } s_t;

  s_t s_r, s_nxt;
  s_t k_r [NB];
  s_t k_nxt [NB];
  logic o_v_r;
  scpd_pkg::out_word_t o_r, o_nxt;

  // error and full scale check; remainder starts at the pulse, below the period unless saturated
  always_comb begin
    s_nxt.v     = pw.valid;
    s_nxt.err   = pw.err || (period == 16'd0);
    s_nxt.sat   = (pw.pulse >= period);
    s_nxt.pulse = pw.pulse;
    s_nxt.rem   = pw.pulse;
    s_nxt.q     = '0;
  end

  // restoring division steps
  always_comb begin
    s_t cur;
    logic [16:0] t;
    logic ge;
    for (int i = 0; i < NB; i++) begin
      cur = (i == 0) ? s_r : k_r[(i == 0) ? 0 : i-1];
      t  = {cur.rem, 1'b0};
      ge = (t >= {1'b0, period});
      k_nxt[i]     = cur;
      k_nxt[i].rem = ge ? 16'(t - {1'b0, period}) : t[15:0];
      k_nxt[i].q   = {cur.q[NB-2:0], ge};
    end
  end

  // final duty select
  always_comb begin
    o_nxt.pulse_us = k_r[NB-1].pulse;
    o_nxt.error    = k_r[NB-1].err;
    if (k_r[NB-1].err) begin
      o_nxt.duty = '0;
    end else if (k_r[NB-1].sat) begin
      o_nxt.duty = scpd_pkg::DUTY_FULL;
    end else begin
      o_nxt.duty = {1'b0, k_r[NB-1].q};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.v <= 1'b0;
      o_v_r <= 1'b0;
      for (int i = 0; i < NB; i++) k_r[i].v <= 1'b0;
    end else if (en) begin
      s_r   <= s_nxt;
      o_v_r <= k_r[NB-1].v;
      o_r   <= o_nxt;
      for (int i = 0; i < NB; i++) k_r[i] <= k_nxt[i];
    end
  end

  assign out_valid = o_v_r;
  assign out_word  = o_r;

endmodule
